@@ src/isovalue_span_histogram_assert.svh @@
`ifndef ISOVALUE_SPAN_HISTOGRAM_ASSERT_SVH
`define ISOVALUE_SPAN_HISTOGRAM_ASSERT_SVH

// same-cycle implication on clk, quiet while arst_n is low
`define ISOH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, quiet while arst_n is low
`define ISOH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/isoh_pkg.sv @@
`default_nettype none

package isoh_pkg;

	localparam int MAX_DIM_DEF = 256;
	localparam int HIST_BINS   = 256;

	localparam int VOX_W     = 8;
	localparam int BIN_W     = 8;
	localparam int CMD_W     = 2;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int COUNT_W   = 25;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam int IN_DATA_W  = VOX_W + BIN_W;
	localparam int OUT_DATA_W = ((2 * COUNT_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_SIZE = 2'd0,
		REG_Y_SIZE = 2'd1,
		REG_Z_SIZE = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		TOK_ADD,
		TOK_READ,
		TOK_CLEAR
	} tok_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_EMIT
	} fe_state_t;

	// one token walking down the bin chain
	typedef struct packed {
		logic               valid;
		tok_kind_t          kind;
		logic [BIN_W-1:0]   lo;
		logic [BIN_W-1:0]   hi;
		logic [COUNT_W-1:0] cnt;
		logic [COUNT_W-1:0] peak;
	} tok_t;

endpackage

`default_nettype wire

@@ src/isoh_ram.sv @@
`default_nettype none

module isoh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ src/isoh_cell.sv @@
`default_nettype none

module isoh_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  isoh_pkg::tok_t tok_in,
	output isoh_pkg::tok_t tok_out
);

	import isoh_pkg::*;

	localparam logic [BIN_W-1:0] MY_BIN = BIN_W'(IDX);

	logic [COUNT_W-1:0] count_q;
	tok_t               tok_s1;
	tok_t               tok_nxt;
	logic               hit;

	assign hit = (tok_in.lo <= MY_BIN) && (MY_BIN <= tok_in.hi);

	// a read picks up its bin and folds every bin but bin 0 into the running peak
	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.valid && tok_in.kind == TOK_READ) begin
			if (tok_in.lo == MY_BIN) begin
				tok_nxt.cnt = count_q;
			end
			if ((IDX != 0) && (count_q > tok_in.peak)) begin
				tok_nxt.peak = count_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tok_s1  <= '0;
		end else if (adv) begin
			tok_s1 <= tok_nxt;
			if (tok_in.valid) begin
				case (tok_in.kind)
					TOK_ADD: begin
						if (hit && count_q != COUNT_MAX) begin
							count_q <= count_q + COUNT_W'(1);
						end
					end
					TOK_CLEAR: count_q <= '0;
					default: ;
				endcase
			end
		end
	end

	assign tok_out = tok_s1;

endmodule

`default_nettype wire

@@ src/isoh_front.sv @@
`default_nettype none

`include "isovalue_span_histogram_assert.svh"

module isoh_front #(
	parameter int MAX_DIM = isoh_pkg::MAX_DIM_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  isoh_pkg::cmd_t              in_cmd,
	input  logic [isoh_pkg::VOX_W-1:0]  in_voxel,
	input  logic [isoh_pkg::BIN_W-1:0]  in_bin,
	input  logic [isoh_pkg::CFG_W-1:0]  x_size,
	input  logic [isoh_pkg::CFG_W-1:0]  y_size,
	input  logic [isoh_pkg::CFG_W-1:0]  z_size,
	input  logic                        adv,
	output isoh_pkg::tok_t              head
);

	import isoh_pkg::*;

	localparam int CW = $clog2(MAX_DIM);
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int AW = 2 * CW + 1;
	localparam int EW = (DW > CFG_W) ? DW : CFG_W;

	function automatic logic [DW-1:0] dim_of(input logic [CFG_W-1:0] r);
		logic [EW-1:0] rx;
		rx = EW'(r);
		if (r == '0) dim_of = DW'(1);
		else if (rx > EW'(MAX_DIM)) dim_of = DW'(MAX_DIM);
		else dim_of = DW'(rx);
	endfunction

	fe_state_t         state_q, state_d;
	logic [DW-1:0]     nx, ny, nz;
	logic [CW-1:0]     px_q, py_q, px_n, py_n;
	logic [DW-1:0]     pz_q, pz_n;
	logic              full, accept, push_go;
	logic [1:0]        ox, oy, oz;
	logic [7:0]        mask_new, mask_q, mask_rest;
	logic [2:0]        sel, k_q;
	logic [CW-1:0]     bx, by, cx, cy;
	logic              bz0, cz0;
	logic              rd_v_s1;
	logic [2:0]        rd_k_s1;
	logic [VOX_W-1:0]  rd_data, lo_q, hi_q;
	logic [AW-1:0]     waddr, raddr;
	logic              pend_load, pos_adv, pos_clear;
	tok_t              pend_q, pend_tok;

	assign nx = dim_of(x_size);
	assign ny = dim_of(y_size);
	assign nz = dim_of(z_size);

	assign full     = (pz_q >= nz);
	assign in_ready = (state_q == ST_IDLE) && !pend_q.valid;
	assign accept   = in_valid && in_ready;
	assign push_go  = accept && (in_cmd == CMD_PUSH) && !full;

	// per axis: bit 0 base is coordinate minus one, bit 1 base is the coordinate itself
	assign ox = {DW'(px_q) == nx - DW'(1), px_q != '0};
	assign oy = {DW'(py_q) == ny - DW'(1), py_q != '0};
	assign oz = {pz_q == nz - DW'(1), pz_q != '0};

	for (genvar g = 0; g < 8; g++) begin : g_mask
		assign mask_new[g] = ox[g % 2] & oy[(g / 2) % 2] & oz[g / 4];
	end

	always_comb begin
		sel = '0;
		for (int i = 7; i >= 0; i--) begin
			if (mask_q[i]) sel = 3'(i);
		end
	end

	assign mask_rest = mask_q & ~(8'b1 << sel);

	// corner coordinate is the base on the low side and the current voxel on the high side
	assign bx  = sel[0] ? px_q : px_q - CW'(1);
	assign by  = sel[1] ? py_q : py_q - CW'(1);
	assign bz0 = sel[2] ? pz_q[0] : ~pz_q[0];
	assign cx  = k_q[0] ? px_q : bx;
	assign cy  = k_q[1] ? py_q : by;
	assign cz0 = k_q[2] ? pz_q[0] : bz0;

	assign raddr = {cz0, cy, cx};
	assign waddr = {pz_q[0], py_q, px_q};

	isoh_ram #(
		.WIDTH(VOX_W),
		.DEPTH(2 ** AW)
	) u_vox_ram (
		.clk  (clk),
		.we   (push_go),
		.waddr(waddr),
		.wdata(in_voxel),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_comb begin
		px_n = px_q + CW'(1);
		py_n = py_q;
		pz_n = pz_q;
		if (DW'(px_q) >= nx - DW'(1)) begin
			px_n = '0;
			if (DW'(py_q) >= ny - DW'(1)) begin
				py_n = '0;
				pz_n = pz_q + DW'(1);
			end else begin
				py_n = py_q + CW'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (push_go && mask_new != '0) state_d = ST_READ;
			end
			ST_READ: begin
				if (&k_q) state_d = ST_WAIT;
			end
			ST_WAIT: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!pend_q.valid) state_d = (mask_rest == '0) ? ST_IDLE : ST_READ;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pend_load = 1'b0;
		pos_adv   = 1'b0;
		pos_clear = 1'b0;
		pend_tok  = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_cmd)
						CMD_PUSH: pos_adv = !full && (mask_new == '0);
						CMD_READ: begin
							pend_load      = 1'b1;
							pend_tok.valid = 1'b1;
							pend_tok.kind  = TOK_READ;
							pend_tok.lo    = in_bin;
						end
						CMD_CLEAR: begin
							pend_load      = 1'b1;
							pend_tok.valid = 1'b1;
							pend_tok.kind  = TOK_CLEAR;
							pos_clear      = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_EMIT: begin
				if (!pend_q.valid) begin
					pend_load      = 1'b1;
					pend_tok.valid = 1'b1;
					pend_tok.kind  = TOK_ADD;
					pend_tok.lo    = lo_q;
					pend_tok.hi    = hi_q;
					pos_adv        = (mask_rest == '0);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			px_q    <= '0;
			py_q    <= '0;
			pz_q    <= '0;
			mask_q  <= '0;
			k_q     <= '0;
			rd_v_s1 <= 1'b0;
			rd_k_s1 <= '0;
			pend_q  <= '0;
		end else begin
			state_q <= state_d;
			if (pos_clear) begin
				px_q <= '0;
				py_q <= '0;
				pz_q <= '0;
			end else if (pos_adv) begin
				px_q <= px_n;
				py_q <= py_n;
				pz_q <= pz_n;
			end
			if (push_go) begin
				mask_q <= mask_new;
			end else if (state_q == ST_EMIT && !pend_q.valid) begin
				mask_q <= mask_rest;
			end
			k_q     <= (state_q == ST_READ) ? k_q + 3'd1 : '0;
			rd_v_s1 <= (state_q == ST_READ);
			rd_k_s1 <= k_q;
			if (pend_load) begin
				pend_q <= pend_tok;
			end else if (adv) begin
				pend_q.valid <= 1'b0;
			end
		end
	end

	// corner min and max, first corner of a cell restarts the pair
	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			if (rd_k_s1 == '0) begin
				lo_q <= rd_data;
				hi_q <= rd_data;
			end else begin
				if (rd_data < lo_q) lo_q <= rd_data;
				if (rd_data > hi_q) hi_q <= rd_data;
			end
		end
	end

	assign head = pend_q;

	`ISOH_ASSERT_NOW(a_pend_free_on_load, pend_load, !pend_q.valid, "entry slot overwritten")
	`ISOH_ASSERT_NOW(a_span_ordered, state_q == ST_EMIT, lo_q <= hi_q, "cell span inverted")
	`ISOH_ASSERT_NEXT(a_last_corner, (state_q == ST_READ) && (&k_q), (state_q == ST_WAIT) && rd_v_s1, "corner sequence broken")

endmodule

`default_nettype wire

@@ src/isovalue_span_histogram.sv @@
// channel   dir  beat fields (lsb first)                 when taken
// s_axis    in   tdata: voxel, bin; tuser: cmd           tvalid & tready
// m_axis    out  tdata: bin_count, peak_count            tvalid & tready
// cfg       in   cfg_wdata -> x_size/y_size/z_size       cfg_we
//
// push: each completed cell reads its corners on the voxel store read port, then
//   hands its span on; an interior voxel completes one cell, a boundary one up to 8
// read, clear, unused command, push past the volume end: taken with no corner reads
// a read token walks the bin chain, one register per bin, then the output register
// arst_n clears bins and position and sets sizes to 1; the voxel store is not cleared
// a stalled m_axis freezes the whole chain; s_axis waits while the chain entry is full
`default_nettype none

`include "isovalue_span_histogram_assert.svh"

module isovalue_span_histogram #(
	parameter int MAX_DIM = isoh_pkg::MAX_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [isoh_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // voxel, bin
	input  logic [isoh_pkg::CMD_W-1:0]          s_axis_tuser,  // cmd
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [isoh_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // bin_count, peak_count, zero pad
	input  logic                                cfg_we,
	input  logic [isoh_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [isoh_pkg::CFG_W-1:0]          cfg_wdata
);

	import isoh_pkg::*;

	logic [CFG_W-1:0]   x_size_q, y_size_q, z_size_q;
	logic               adv;
	tok_t               chain [HIST_BINS+1];
	tok_t               tail;
	logic               out_v_q;
	logic [COUNT_W-1:0] bin_count_q, peak_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_size_q <= CFG_W'(1);
			y_size_q <= CFG_W'(1);
			z_size_q <= CFG_W'(1);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_X_SIZE: x_size_q <= cfg_wdata;
				REG_Y_SIZE: y_size_q <= cfg_wdata;
				REG_Z_SIZE: z_size_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign adv = !out_v_q || m_axis_tready;

	isoh_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_cmd  (cmd_t'(s_axis_tuser)),
		.in_voxel(s_axis_tdata[VOX_W-1:0]),
		.in_bin  (s_axis_tdata[VOX_W +: BIN_W]),
		.x_size  (x_size_q),
		.y_size  (y_size_q),
		.z_size  (z_size_q),
		.adv     (adv),
		.head    (chain[0])
	);

	for (genvar i = 0; i < HIST_BINS; i++) begin : g_cell
		isoh_cell #(
			.IDX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.tok_in (chain[i]),
			.tok_out(chain[i+1])
		);
	end

	assign tail = chain[HIST_BINS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= tail.valid && (tail.kind == TOK_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tail.valid && tail.kind == TOK_READ) begin
			bin_count_q  <= tail.cnt;
			peak_count_q <= tail.peak;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - 2 * COUNT_W){1'b0}}, peak_count_q, bin_count_q};

	`ISOH_ASSERT_NEXT(a_chain_holds, !adv, $stable(tail), "bin chain moved while output stalled")
	`ISOH_ASSERT_NEXT(a_no_spurious_out, adv && !(tail.valid && tail.kind == TOK_READ), !m_axis_tvalid, "result without read token")
	`ISOH_ASSERT_NEXT(a_read_lands, adv && tail.valid && tail.kind == TOK_READ, m_axis_tvalid && (bin_count_q == $past(tail.cnt)), "read token lost at output")

endmodule

`default_nettype wire

@@ dv/tb_isovalue_span_histogram.sv @@
module tb_isovalue_span_histogram;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNT_W        = isoh_pkg::COUNT_W;
	localparam int DIM_MAX        = isoh_pkg::MAX_DIM_DEF;
	localparam int STORE_DEPTH    = DIM_MAX * DIM_MAX + DIM_MAX + 2;
	// worst push in the front end plus two trips down the bin chain
	localparam int SETTLE_CYCLES  = 81 + 2 * (isoh_pkg::HIST_BINS + 2) + 50;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef enum {MODE_FLOW, MODE_SEND_IDLE, MODE_RECV_STALL, MODE_BOTH_IDLE} idle_mode_t;

	typedef struct packed {
		isoh_pkg::cmd_t cmd;
		logic [7:0]     voxel;
		logic [7:0]     bin;
	} hist_beat_t;

	typedef struct packed {
		logic [COUNT_W-1:0] bin_count;
		logic [COUNT_W-1:0] peak_count;
	} read_result_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                s_axis_tvalid = 1'b0;
	logic                                s_axis_tready;
	logic [isoh_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;   // voxel, bin
	logic [isoh_pkg::CMD_W-1:0]          s_axis_tuser = '0;   // cmd
	logic                                m_axis_tvalid;
	logic                                m_axis_tready = 1'b0;
	logic [isoh_pkg::OUT_DATA_W-1:0]     m_axis_tdata;        // bin_count, peak_count, zero pad
	logic                                cfg_we = 1'b0;
	logic [isoh_pkg::CFG_IDX_W-1:0]      cfg_addr = '0;
	logic [isoh_pkg::CFG_W-1:0]          cfg_wdata = '0;

	hist_beat_t   pending_beats[$];
	read_result_t expected_reads[$];
	idle_mode_t   idle_mode = MODE_FLOW;
	bit           s_beat_taken = 1'b0;
	int           mismatches = 0;
	int           stuck_cycles = 0;

	// predicted block state
	logic [7:0]                  vox_mem [STORE_DEPTH];
	logic [COUNT_W-1:0]          span_hist [isoh_pkg::HIST_BINS];
	logic [COUNT_W-1:0]          span_peak = '0;
	int                          vol_pos = 0;
	logic [isoh_pkg::CFG_W-1:0]  size_reg [3] = '{9'd1, 9'd1, 9'd1};

	isovalue_span_histogram u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int eff_dim(logic [isoh_pkg::CFG_W-1:0] r);
		if (r == 0) return 1;
		if (r > DIM_MAX) return DIM_MAX;
		return r;
	endfunction

	// candidate base c-1 exists past the origin, candidate c only at the far edge
	function automatic bit base_ok(int c, int n, int o);
		return (o == 0) ? (c >= 1) : (c == n - 1);
	endfunction

	function automatic void add_cell_span(int bx, int by, int bz, int nx, int ny, int nz);
		int base_pos, sx, sy, sz, q, lo, hi, v;
		base_pos = bz * nx * ny + by * nx + bx;
		sx = (bx + 1 < nx) ? 1 : 0;
		sy = (by + 1 < ny) ? nx : 0;
		sz = (bz + 1 < nz) ? nx * ny : 0;
		lo = 255;
		hi = 0;
		for (int c = 0; c < 8; c++) begin
			q = base_pos + (((c & 1) != 0) ? sx : 0) + (((c & 2) != 0) ? sy : 0)
				+ (((c & 4) != 0) ? sz : 0);
			v = vox_mem[q % STORE_DEPTH];
			if (v < lo) lo = v;
			if (v > hi) hi = v;
		end
		for (int m = lo; m <= hi; m++) begin
			if (span_hist[m] != isoh_pkg::COUNT_MAX) span_hist[m] = span_hist[m] + 1'b1;
			if (m >= 1 && span_hist[m] > span_peak) span_peak = span_hist[m];
		end
	endfunction

	function automatic void take_voxel(logic [7:0] v);
		int nx, ny, nz, px, py, pz;
		nx = eff_dim(size_reg[isoh_pkg::REG_X_SIZE]);
		ny = eff_dim(size_reg[isoh_pkg::REG_Y_SIZE]);
		nz = eff_dim(size_reg[isoh_pkg::REG_Z_SIZE]);
		if (vol_pos >= nx * ny * nz) return;
		vox_mem[vol_pos % STORE_DEPTH] = v;
		px = vol_pos % nx;
		py = (vol_pos / nx) % ny;
		pz = vol_pos / (nx * ny);
		for (int oz = 0; oz < 2; oz++)
			for (int oy = 0; oy < 2; oy++)
				for (int ox = 0; ox < 2; ox++)
					if (base_ok(px, nx, ox) && base_ok(py, ny, oy) && base_ok(pz, nz, oz))
						add_cell_span(px - 1 + ox, py - 1 + oy, pz - 1 + oz, nx, ny, nz);
		vol_pos++;
	endfunction

	function automatic void apply_beat(isoh_pkg::cmd_t c, logic [7:0] v, logic [7:0] b);
		read_result_t r;
		case (c)
			isoh_pkg::CMD_PUSH: take_voxel(v);
			isoh_pkg::CMD_READ: begin
				r.bin_count  = span_hist[b];
				r.peak_count = span_peak;
				expected_reads.push_back(r);
			end
			isoh_pkg::CMD_CLEAR: begin
				foreach (span_hist[i]) span_hist[i] = '0;
				span_peak = '0;
				vol_pos   = 0;
			end
			default: ;
		endcase
	endfunction

	function automatic bit roll(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic bit sender_gap();
		case (idle_mode)
			MODE_SEND_IDLE: return roll(67);
			MODE_BOTH_IDLE: return roll(6);
			default:        return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stall();
		case (idle_mode)
			MODE_RECV_STALL: return roll(67);
			MODE_BOTH_IDLE:  return roll(6);
			default:         return 1'b0;
		endcase
	endfunction

	// input side: sample at the rising edge, drive at the falling edge
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			apply_beat(isoh_pkg::cmd_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[15:8]);
			s_beat_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		hist_beat_t nxt;
		if (arst_n && (!s_axis_tvalid || s_beat_taken)) begin
			if (pending_beats.size() != 0 && !sender_gap()) begin
				nxt = pending_beats.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {nxt.bin, nxt.voxel};
				s_axis_tuser  <= nxt.cmd;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		s_beat_taken = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready <= arst_n && !receiver_stall();
	end

	task automatic report_mismatch(string what, read_result_t want, read_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected bin_count %0d peak_count %0d, got %0d %0d",
				what, want.bin_count, want.peak_count, got.bin_count, got.peak_count);
	endtask

	always @(posedge clk) begin
		read_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.bin_count  = m_axis_tdata[COUNT_W-1:0];
			got.peak_count = m_axis_tdata[2*COUNT_W-1:COUNT_W];
			if (expected_reads.size() == 0) begin
				report_mismatch("(no read pending)", '0, got);
			end else begin
				want = expected_reads.pop_front();
				if (got.bin_count !== want.bin_count || got.peak_count !== want.peak_count)
					report_mismatch("on read beat", want, got);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("isovalue_span_histogram test failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic queue_beat(isoh_pkg::cmd_t c, logic [7:0] v, logic [7:0] b);
		hist_beat_t nb;
		nb.cmd   = c;
		nb.voxel = v;
		nb.bin   = b;
		pending_beats.push_back(nb);
	endtask

	// wait until every beat is in, every read is back and the chain is empty
	task automatic settle();
		while (pending_beats.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (expected_reads.size() != 0) @(posedge clk);
		idle_mode = MODE_FLOW;
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(isoh_pkg::reg_idx_t idx, logic [isoh_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		size_reg[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_sizes(logic [8:0] xs, logic [8:0] ys, logic [8:0] zs);
		settle();
		write_reg(isoh_pkg::REG_X_SIZE, xs);
		write_reg(isoh_pkg::REG_Y_SIZE, ys);
		write_reg(isoh_pkg::REG_Z_SIZE, zs);
	endtask

	// whole volumes of random voxels with reads mixed in, up to two pushes past the end
	task automatic run_phase(logic [8:0] xs, logic [8:0] ys, logic [8:0] zs,
		idle_mode_t mode, int budget);
		int vol, sent, n, lo_v, hi_v;
		set_sizes(xs, ys, zs);
		idle_mode = mode;
		vol  = eff_dim(xs) * eff_dim(ys) * eff_dim(zs);
		sent = 0;
		while (sent < budget) begin
			queue_beat(isoh_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom));
			sent++;
			if (roll(30)) begin
				lo_v = 0;
				hi_v = 255;
			end else begin
				lo_v = $urandom_range(0, 255);
				hi_v = $urandom_range(lo_v, (lo_v + 40 > 255) ? 255 : lo_v + 40);
			end
			n = vol + $urandom_range(0, 2);
			for (int i = 0; i < n && sent < budget; i++) begin
				queue_beat(isoh_pkg::CMD_PUSH, 8'($urandom_range(lo_v, hi_v)), 8'($urandom));
				sent++;
				if (roll(15)) begin
					queue_beat(isoh_pkg::CMD_READ, 8'($urandom),
						roll(50) ? 8'($urandom_range(lo_v, hi_v)) : 8'($urandom));
					sent++;
				end else if (roll(3)) begin
					queue_beat(isoh_pkg::CMD_NONE, 8'($urandom), 8'($urandom));
				end
			end
			repeat (3) begin
				queue_beat(isoh_pkg::CMD_READ, 8'($urandom),
					roll(50) ? 8'($urandom_range(lo_v, hi_v)) : 8'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		foreach (span_hist[i]) span_hist[i] = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// one-voxel volume at reset sizes
		queue_beat(isoh_pkg::CMD_READ,  8'h00, 8'h00);
		queue_beat(isoh_pkg::CMD_PUSH,  8'h00, 8'hFF);
		queue_beat(isoh_pkg::CMD_PUSH,  8'hFF, 8'h00);  // volume already full
		queue_beat(isoh_pkg::CMD_READ,  8'hFF, 8'h00);
		queue_beat(isoh_pkg::CMD_READ,  8'h00, 8'hFF);
		queue_beat(isoh_pkg::CMD_NONE,  8'hFF, 8'hFF);
		queue_beat(isoh_pkg::CMD_READ,  8'h00, 8'h00);
		queue_beat(isoh_pkg::CMD_CLEAR, 8'hFF, 8'hFF);
		queue_beat(isoh_pkg::CMD_PUSH,  8'hFF, 8'h00);
		queue_beat(isoh_pkg::CMD_READ,  8'h00, 8'hFF);
		queue_beat(isoh_pkg::CMD_READ,  8'h00, 8'h00);

		// two-voxel row: full span cell plus the clamped one at the edge
		set_sizes(9'd2, 9'd1, 9'd1);
		queue_beat(isoh_pkg::CMD_CLEAR, 8'h00, 8'h00);
		queue_beat(isoh_pkg::CMD_PUSH,  8'h00, 8'h00);
		queue_beat(isoh_pkg::CMD_PUSH,  8'hFF, 8'h00);
		queue_beat(isoh_pkg::CMD_READ,  8'h00, 8'h80);
		queue_beat(isoh_pkg::CMD_READ,  8'h00, 8'hFF);
		queue_beat(isoh_pkg::CMD_READ,  8'h00, 8'h00);

		run_phase(9'd3,   9'd2,   9'd2,   MODE_FLOW,       120);
		run_phase(9'd256, 9'd1,   9'd1,   MODE_SEND_IDLE,  150);
		run_phase(9'd0,   9'd0,   9'd0,   MODE_RECV_STALL,  80);
		run_phase(9'd2,   9'd511, 9'd1,   MODE_BOTH_IDLE,  120);
		run_phase(9'd1,   9'd1,   9'd256, MODE_FLOW,       100);
		run_phase(9'd5,   9'd4,   9'd3,   MODE_RECV_STALL, 150);
		run_phase(9'd2,   9'd2,   9'd2,   MODE_SEND_IDLE,  100);
		run_phase(9'($urandom_range(1, 6)), 9'($urandom_range(1, 6)),
			9'($urandom_range(1, 6)), MODE_BOTH_IDLE, 90);

		settle();
		mismatches += expected_reads.size();
		if (mismatches == 0) begin
			$display("isovalue_span_histogram test passed");
		end else begin
			$display("isovalue_span_histogram test failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/isoh_pkg.sv
src/isoh_ram.sv
src/isoh_cell.sv
src/isoh_front.sv
src/isovalue_span_histogram.sv
dv/tb_isovalue_span_histogram.sv
